// ----- src/sbe_pkg.sv -----
// sbe_pkg: opcodes, status codes and sequencer states of the stack bytecode executor
// no dependencies
package sbe_pkg;

	// opcodes
	typedef logic [3:0] opcode_t;
	localparam opcode_t OP_NOP    = 4'd0;
	localparam opcode_t OP_IPUSH  = 4'd1;
	localparam opcode_t OP_BIPUSH = 4'd2;
	localparam opcode_t OP_POP    = 4'd3;
	localparam opcode_t OP_ADD    = 4'd4;
	localparam opcode_t OP_SUB    = 4'd5;
	localparam opcode_t OP_MUL    = 4'd6;
	localparam opcode_t OP_DIV    = 4'd7;
	localparam opcode_t OP_MOD    = 4'd8;
	localparam opcode_t OP_SWAP   = 4'd9;
	localparam opcode_t OP_DUP    = 4'd10;
	localparam opcode_t OP_STORE  = 4'd11;
	localparam opcode_t OP_LOAD   = 4'd12;
	localparam opcode_t OP_HALT   = 4'd13;

	// status codes
	typedef logic [3:0] status_t;
	localparam status_t ST_OK      = 4'd0;
	localparam status_t ST_HALTED  = 4'd1;
	localparam status_t ST_OVF     = 4'd2;
	localparam status_t ST_UNF     = 4'd3;
	localparam status_t ST_DIVZ    = 4'd4;
	localparam status_t ST_UNINIT  = 4'd5;
	localparam status_t ST_RANGE   = 4'd6;
	localparam status_t ST_UNKNOWN = 4'd7;
	localparam status_t ST_FAULTED = 4'd8;

	localparam int WORD_W = 32;

	// sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_DIV,
		S_SWAP2,
		S_LOAD,
		S_DONE
	} seq_state_t;

endpackage

// ----- src/sbe_ram.sv -----
// sbe_ram: generic single write, single read RAM with registered read data
// no dependencies
module sbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/stack_bytecode_executor_top.sv -----
// stack_bytecode_executor_top: stack machine executing one instruction per input word
// depends on sbe_pkg and sbe_ram
// each input word passes through idle, exec and done; a fault goes from exec straight to done;
// pop and store add read unless they leave fewer than one entry below, add, sub and mul add
// read, swap adds read and swap2, load adds load, and div and mod add read and div (one
// quotient bit a cycle on the shared subtractor); one word in flight, the next is taken once
// the previous reaches the output register. after reset a clearing pass zeroes each of the
// LOCAL_SLOTS local slots before the first word is accepted.
module stack_bytecode_executor_top #(
	parameter int STACK_DEPTH = 256,
	parameter int LOCAL_SLOTS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sbe_pkg::opcode_t     kind,
	input  logic signed [31:0]   immediate,
	input  logic [15:0]          slot_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sbe_pkg::status_t     status,
	output logic signed [31:0]   top_value,
	output logic [8:0]           stack_depth
);
	import sbe_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int LW  = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
	localparam int HWW = $clog2(LOCAL_SLOTS + 1);

	seq_state_t state_q, state_nx;

	opcode_t            kind_q;
	logic [WORD_W-1:0]  imm_q;
	logic [15:0]        slot_q;
	logic [SPW-1:0]     sp_q;
	logic [WORD_W-1:0]  top_q;
	logic [HWW-1:0]     hw_q;
	logic [2:0]         fault_q;
	status_t            st_q;
	logic [LW-1:0]      clr_cnt_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [WORD_W-1:0]  top_out_q;
	logic [8:0]         depth_q;

	// divider registers
	logic [WORD_W-1:0]  rem_q, quo_q, dvs_q;
	logic [4:0]         div_cnt_q;
	logic               negq_q, negr_q;

	// memory ports
	logic               s_we, l_we;
	logic [AW-1:0]      s_waddr, s_raddr;
	logic [WORD_W-1:0]  s_wdata, s_rdata;
	logic [LW-1:0]      l_waddr, l_raddr;
	logic [WORD_W-1:0]  l_wdata, l_rdata;

	logic [WORD_W-1:0]  push_val, alu_res, div_res, a_mag, b_mag;
	logic [WORD_W:0]    div_sh, div_diff;
	logic [WORD_W-1:0]  rem_nx, quo_nx;
	logic               q_bit;
	status_t            exec_st;
	logic               slot_ok, slot_init, sp_full, sp_lt2, sp_zero, out_free;
	logic [AW-1:0]      sp_m1, sp_m2;

	sbe_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	sbe_ram #(.WIDTH(WORD_W), .DEPTH(LOCAL_SLOTS)) u_slots (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	// stack and slot conditions
	assign sp_full   = sp_q >= SPW'(STACK_DEPTH);
	assign sp_lt2    = sp_q < SPW'(2);
	assign sp_zero   = sp_q == '0;
	assign slot_ok   = {1'b0, slot_q} < 17'(LOCAL_SLOTS);
	assign slot_init = {1'b0, slot_q} < 17'(hw_q);
	assign sp_m1     = AW'(sp_q - SPW'(1));
	assign sp_m2     = AW'(sp_q - SPW'(2));
	assign out_free  = !out_valid_q || out_ready;

	assign push_val = (kind_q == OP_BIPUSH) ? {{24{imm_q[7]}}, imm_q[7:0]} : imm_q;

	// fault checks, in priority order per opcode
	always_comb begin
		exec_st = ST_OK;
		case (kind_q)
			OP_NOP: exec_st = ST_OK;
			OP_IPUSH, OP_BIPUSH: if (sp_full) exec_st = ST_OVF;
			OP_POP: if (sp_zero) exec_st = ST_UNF;
			OP_ADD, OP_SUB, OP_MUL, OP_SWAP: if (sp_lt2) exec_st = ST_UNF;
			OP_DIV, OP_MOD: begin
				if (sp_lt2) exec_st = ST_UNF;
				else if (top_q == '0) exec_st = ST_DIVZ;
			end
			OP_DUP: begin
				if (sp_zero) exec_st = ST_UNF;
				else if (sp_full) exec_st = ST_OVF;
			end
			OP_STORE: begin
				if (sp_zero) exec_st = ST_UNF;
				else if (!slot_ok) exec_st = ST_RANGE;
			end
			OP_LOAD: begin
				if (!slot_ok) exec_st = ST_RANGE;
				else if (!slot_init) exec_st = ST_UNINIT;
				else if (sp_full) exec_st = ST_OVF;
			end
			OP_HALT: exec_st = ST_HALTED;
			default: exec_st = ST_UNKNOWN;
		endcase
	end

	// add, sub, mul on second entry and cached top
	always_comb begin
		case (kind_q)
			OP_ADD:  alu_res = s_rdata + top_q;
			OP_SUB:  alu_res = s_rdata - top_q;
			default: alu_res = s_rdata * top_q;
		endcase
	end

	// operand magnitudes for the divider
	assign a_mag = s_rdata[31] ? (~s_rdata + 32'd1) : s_rdata;
	assign b_mag = top_q[31] ? (~top_q + 32'd1) : top_q;

	// one restoring step of the shared subtractor
	assign div_sh   = {rem_q, quo_q[31]};
	assign div_diff = div_sh - {1'b0, dvs_q};
	assign q_bit    = !div_diff[WORD_W];
	assign rem_nx   = q_bit ? div_diff[WORD_W-1:0] : div_sh[WORD_W-1:0];
	assign quo_nx   = {quo_q[30:0], q_bit};
	always_comb begin
		if (kind_q == OP_DIV) div_res = negq_q ? (~quo_nx + 32'd1) : quo_nx;
		else div_res = negr_q ? (~rem_nx + 32'd1) : rem_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR: if (clr_cnt_q == LW'(LOCAL_SLOTS - 1)) state_nx = S_IDLE;
			S_IDLE: if (in_valid) state_nx = S_EXEC;
			S_EXEC: begin
				if (fault_q != '0 || exec_st != ST_OK) state_nx = S_DONE;
				else begin
					case (kind_q)
						OP_POP, OP_STORE: state_nx = sp_lt2 ? S_DONE : S_READ;
						OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SWAP: state_nx = S_READ;
						OP_LOAD: state_nx = S_LOAD;
						default: state_nx = S_DONE;
					endcase
				end
			end
			S_READ: begin
				if (kind_q == OP_DIV || kind_q == OP_MOD) state_nx = S_DIV;
				else if (kind_q == OP_SWAP) state_nx = S_SWAP2;
				else state_nx = S_DONE;
			end
			S_DIV: if (div_cnt_q == 5'd31) state_nx = S_DONE;
			S_SWAP2: state_nx = S_DONE;
			S_LOAD: state_nx = S_DONE;
			S_DONE: if (out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		s_we    = 1'b0;
		s_waddr = sp_q[AW-1:0];
		s_wdata = top_q;
		s_raddr = sp_m2;
		l_we    = 1'b0;
		l_waddr = slot_q[LW-1:0];
		l_wdata = top_q;
		l_raddr = slot_q[LW-1:0];
		case (state_q)
			S_CLEAR: begin
				l_we    = 1'b1;
				l_waddr = clr_cnt_q;
				l_wdata = '0;
			end
			S_EXEC: begin
				if (fault_q == '0 && exec_st == ST_OK) begin
					if (kind_q == OP_IPUSH || kind_q == OP_BIPUSH) begin
						s_we    = 1'b1;
						s_wdata = push_val;
					end else if (kind_q == OP_DUP) begin
						s_we = 1'b1;
					end else if (kind_q == OP_STORE) begin
						l_we = 1'b1;
					end
				end
			end
			S_READ: begin
				s_waddr = sp_m2;
				if (kind_q == OP_ADD || kind_q == OP_SUB || kind_q == OP_MUL) begin
					s_we    = 1'b1;
					s_wdata = alu_res;
				end else if (kind_q == OP_SWAP) begin
					s_we = 1'b1;
				end
			end
			S_DIV: begin
				s_waddr = sp_m2;
				s_wdata = div_res;
				s_we    = div_cnt_q == 5'd31;
			end
			S_SWAP2: begin
				s_we    = 1'b1;
				s_waddr = sp_m1;
			end
			S_LOAD: begin
				s_we    = 1'b1;
				s_wdata = l_rdata;
			end
			default: s_we = 1'b0;
		endcase
	end

	// sequencer, stack pointer, cached top, divider and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			kind_q      <= OP_NOP;
			imm_q       <= '0;
			slot_q      <= '0;
			sp_q        <= '0;
			top_q       <= '0;
			hw_q        <= '0;
			fault_q     <= '0;
			st_q        <= ST_OK;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			top_out_q   <= '0;
			depth_q     <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			dvs_q       <= '0;
			div_cnt_q   <= '0;
			negq_q      <= 1'b0;
			negr_q      <= 1'b0;
		end else begin
			state_q <= state_nx;
			// output word handshake
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: clr_cnt_q <= clr_cnt_q + LW'(1);
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= kind;
						imm_q  <= immediate;
						slot_q <= slot_index;
					end
				end
				S_EXEC: begin
					if (fault_q != '0) begin
						st_q <= (fault_q == ST_HALTED[2:0]) ? ST_HALTED : ST_FAULTED;
					end else begin
						st_q    <= exec_st;
						fault_q <= exec_st[2:0];
						if (exec_st == ST_OK) begin
							case (kind_q)
								OP_IPUSH, OP_BIPUSH: begin
									top_q <= push_val;
									sp_q  <= sp_q + SPW'(1);
								end
								OP_DUP: sp_q <= sp_q + SPW'(1);
								OP_POP, OP_STORE: begin
									sp_q <= sp_q - SPW'(1);
									if (sp_lt2) top_q <= '0;
									if (kind_q == OP_STORE && !slot_init) begin
										hw_q <= HWW'({1'b0, slot_q} + 17'd1);
									end
								end
								default: sp_q <= sp_q;
							endcase
						end
					end
				end
				S_READ: begin
					case (kind_q)
						OP_ADD, OP_SUB, OP_MUL: begin
							top_q <= alu_res;
							sp_q  <= sp_q - SPW'(1);
						end
						OP_DIV, OP_MOD: begin
							rem_q     <= '0;
							quo_q     <= a_mag;
							dvs_q     <= b_mag;
							div_cnt_q <= '0;
							negq_q    <= s_rdata[31] ^ top_q[31];
							negr_q    <= s_rdata[31];
						end
						default: top_q <= s_rdata;
					endcase
				end
				S_DIV: begin
					rem_q     <= rem_nx;
					quo_q     <= quo_nx;
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						top_q <= div_res;
						sp_q  <= sp_q - SPW'(1);
					end
				end
				S_LOAD: begin
					top_q <= l_rdata;
					sp_q  <= sp_q + SPW'(1);
				end
				S_DONE: begin
					if (out_free) begin
						status_q    <= st_q;
						top_out_q   <= sp_zero ? '0 : top_q;
						depth_q     <= 9'(sp_q);
					end
				end
				default: clr_cnt_q <= clr_cnt_q;
			endcase
		end
	end

	assign in_ready    = state_q == S_IDLE;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign top_value   = top_out_q;
	assign stack_depth = depth_q;

	// checks
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q != '0 |=> fault_q == $past(fault_q))
		else $error("fault code changed after fault");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && depth_q == '0 |-> top_out_q == '0)
		else $error("nonzero top on empty stack");

	a_fault_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && fault_q != '0 |=> $stable(sp_q) && $stable(hw_q))
		else $error("state changed while faulted");

endmodule
